### rtl/byte_histogram_frequency_defines.svh
// ----------------------------------------------------------------------------
// Byte histogram assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_HISTOGRAM_FREQUENCY_DEFINES_SVH
`define BYTE_HISTOGRAM_FREQUENCY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bhf_pkg.sv
// ----------------------------------------------------------------------------
// Byte histogram package
// Widths, action codes, constants and the saturating increment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhf_pkg;

   localparam int COUNT_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int FREQ_BITS  = FRAC_BITS + 1;
   localparam int STEP_BITS  = $clog2(FRAC_BITS + 1);
   localparam int NUM_BINS   = 256;
   localparam int SYM_BITS   = $clog2(NUM_BINS);
   localparam int WORD_BITS  = 64;
   localparam int MASK_WORDS = NUM_BINS / WORD_BITS;
   localparam int WSEL_BITS  = $clog2(MASK_WORDS);
   localparam int BSEL_BITS  = $clog2(WORD_BITS);

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [FREQ_BITS-1:0]  freq_type;
   typedef logic [1:0]            action_type;

   localparam action_type ACT_ADD   = 2'd0;
   localparam action_type ACT_QUERY = 2'd1;
   localparam action_type ACT_CLEAR = 2'd2;

   localparam count_type COUNT_MAX = '1;
   localparam freq_type  FREQ_ONE  = freq_type'(1) << FRAC_BITS;

   function automatic count_type sat_inc(input count_type v);
      return (v == COUNT_MAX) ? v : v + count_type'(1);
   endfunction

endpackage

### rtl/byte_histogram_frequency.sv
// ----------------------------------------------------------------------------
// Byte histogram with normalization
// 256-bin saturating histogram held in a synchronous memory, with running
// totals and a Q1.16 relative frequency computed by a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Beat contents
//  req_      in         req_valid/req_stall  action, symbol
//  rsp_      out        rsp_valid/rsp_stall  count, seen, frequency, totals
//  csr_      in         csr_valid/csr_ready  register index, 64-bit data
//
//  Add, clear, the unused code and a query that needs no division: accept with
//  the bin read, then modify, write back (add only) and load the output register.
//  A query that needs a division passes through S_DIV, where the restoring
//  divider retires one quotient bit per cycle, before the output register loads.
//  Clear drops the per-bin valid flags at once, so no clearing pass is needed.
//  Reset is synchronous; a stalled result holds the block once it is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "byte_histogram_frequency_defines.svh"

module byte_histogram_frequency (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [bhf_pkg::SYM_BITS-1:0]   req_symbol,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bhf_pkg::COUNT_BITS-1:0] rsp_symbol_count,
   output logic                           rsp_seen,
   output logic [bhf_pkg::FREQ_BITS-1:0]  rsp_frequency,
   output logic [bhf_pkg::COUNT_BITS-1:0] rsp_selected_total,
   output logic [bhf_pkg::COUNT_BITS-1:0] rsp_all_total,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bhf_pkg::WSEL_BITS-1:0]  csr_index,
   input  logic [bhf_pkg::WORD_BITS-1:0]  csr_data
);
   import bhf_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   count_type                bin_mem [NUM_BINS];
   logic [NUM_BINS-1:0]      bin_vld_ff;
   count_type                rd_data_ff;
   logic                     rd_vld_ff;

   logic [WORD_BITS-1:0]     mask_ff [MASK_WORDS];

   logic [1:0]               state_ff, state_in;
   action_type               act_ff;
   logic [SYM_BITS-1:0]      sym_ff;
   count_type                all_sum_ff, all_sum_in;
   count_type                sel_sum_ff, sel_sum_in;
   count_type                cnt_ff, cnt_in;
   freq_type                 freq_ff, freq_in;
   count_type                rem_ff, rem_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   count_type                rsp_cnt_ff;
   logic                     rsp_seen_ff;
   freq_type                 rsp_freq_ff;
   count_type                rsp_sel_ff;
   count_type                rsp_all_ff;

   logic                     accept;
   logic                     out_free;
   logic                     load_fast;
   logic                     load_slow;
   logic                     mem_we;
   logic                     vld_set;
   logic                     vld_clr;
   logic                     sym_sel;
   logic                     freq_cond;
   count_type                cnt_old;
   count_type                cnt_new;
   freq_type                 freq_fast;
   logic [COUNT_BITS:0]      rem_dbl;
   logic                     q_bit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MASK_WORDS; i++) begin
            mask_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         mask_ff[csr_index] <= csr_data;
      end
   end

   assign sym_sel = mask_ff[sym_ff[SYM_BITS-1:BSEL_BITS]][sym_ff[BSEL_BITS-1:0]];
   assign cnt_old = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      cnt_new    = cnt_old;
      all_sum_in = all_sum_ff;
      sel_sum_in = sel_sum_ff;
      mem_we     = 1'b0;
      vld_set    = 1'b0;
      vld_clr    = 1'b0;
      if (state_ff == S_RD) begin
         case (act_ff)
            ACT_ADD: begin
               cnt_new    = sat_inc(cnt_old);
               all_sum_in = sat_inc(all_sum_ff);
               sel_sum_in = sym_sel ? sat_inc(sel_sum_ff) : sel_sum_ff;
               mem_we     = 1'b1;
               vld_set    = 1'b1;
            end
            ACT_CLEAR: begin
               cnt_new    = '0;
               all_sum_in = '0;
               sel_sum_in = '0;
               vld_clr    = 1'b1;
            end
            default: begin
               cnt_new = cnt_old;
            end
         endcase
      end
   end

   assign freq_cond = (act_ff == ACT_QUERY) && sym_sel && (cnt_old != '0)
                      && (sel_sum_ff != '0);
   assign freq_fast = (freq_cond && (cnt_old >= sel_sum_ff)) ? FREQ_ONE : '0;

   assign rem_dbl = {rem_ff, 1'b0};
   assign q_bit   = (rem_dbl >= {1'b0, sel_sum_ff});

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      freq_in   = freq_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      load_fast = 1'b0;
      load_slow = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cnt_in  = cnt_new;
            freq_in = freq_fast;
            if (freq_cond && (cnt_old < sel_sum_ff)) begin
               freq_in  = '0;
               rem_in   = cnt_old;
               step_in  = STEP_BITS'(FRAC_BITS);
               state_in = S_DIV;
            end else if (out_free) begin
               load_fast = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            freq_in = {freq_ff[FREQ_BITS-2:0], q_bit};
            rem_in  = q_bit ? COUNT_BITS'(rem_dbl - {1'b0, sel_sum_ff})
                            : COUNT_BITS'(rem_dbl);
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == STEP_BITS'(1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               load_slow = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_fast || load_slow) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= bin_mem[req_symbol];
      end
      if (mem_we) begin
         bin_mem[sym_ff] <= cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_vld_ff <= '0;
      end else if (vld_clr) begin
         bin_vld_ff <= '0;
      end else if (vld_set) begin
         bin_vld_ff[sym_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         all_sum_ff   <= '0;
         sel_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         all_sum_ff   <= all_sum_in;
         sel_sum_ff   <= sel_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff    <= req_action;
         sym_ff    <= req_symbol;
         rd_vld_ff <= bin_vld_ff[req_symbol];
      end
      cnt_ff  <= cnt_in;
      freq_ff <= freq_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (load_fast) begin
         rsp_cnt_ff  <= cnt_new;
         rsp_seen_ff <= (cnt_new != '0);
         rsp_freq_ff <= freq_fast;
         rsp_sel_ff  <= sel_sum_in;
         rsp_all_ff  <= all_sum_in;
      end else if (load_slow) begin
         rsp_cnt_ff  <= cnt_ff;
         rsp_seen_ff <= (cnt_ff != '0);
         rsp_freq_ff <= freq_ff;
         rsp_sel_ff  <= sel_sum_ff;
         rsp_all_ff  <= all_sum_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_symbol_count   = rsp_cnt_ff;
   assign rsp_seen           = rsp_seen_ff;
   assign rsp_frequency      = rsp_freq_ff;
   assign rsp_selected_total = rsp_sel_ff;
   assign rsp_all_total      = rsp_all_ff;

   `BHF_ASSERT_NEXT(a_accept_reads, accept, state_ff == S_RD, "accepted beat did not start a read")
   `BHF_ASSERT_NOW(a_div_nonzero, state_ff == S_DIV, sel_sum_ff != '0, "division by a zero total")
   `BHF_ASSERT_NOW(a_totals_order, 1'b1, sel_sum_ff <= all_sum_ff, "selected total above all total")
   `BHF_ASSERT_NOW(a_freq_range, rsp_valid_ff, (rsp_freq_ff <= FREQ_ONE) && ((rsp_freq_ff == '0) || rsp_seen_ff), "frequency out of range or for an unseen symbol")

endmodule

### bench/byte_histogram_frequency_tb.sv
// ----------------------------------------------------------------------------
// Byte histogram with normalization testbench
// A queue-fed driver sends add, query, clear and unused-code beats. A clocked
// monitor checks every result against a local histogram predictor. The run
// goes through several selection mask settings, with random idles on both
// sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_histogram_frequency_tb;

   import bhf_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 4;
   localparam int SETTLE_CYCLES   = 2 + FRAC_BITS + 1 + 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PRESSURE_AT     = 300;
   localparam int PRESSURE_CYCLES = 250;
   localparam int PHASE_BEATS     = 135;

   localparam action_type ACT_UNUSED = 2'd3;

   localparam logic [WSEL_BITS-1:0] REG_MASK_W0 = 2'd0;
   localparam logic [WSEL_BITS-1:0] REG_MASK_W1 = 2'd1;
   localparam logic [WSEL_BITS-1:0] REG_MASK_W2 = 2'd2;
   localparam logic [WSEL_BITS-1:0] REG_MASK_W3 = 2'd3;

   typedef struct packed {
      action_type          action;
      logic [SYM_BITS-1:0] symbol;
   } hist_beat_type;

   typedef struct packed {
      count_type symbol_count;
      logic      seen;
      freq_type  frequency;
      count_type selected_total;
      count_type all_total;
   } hist_result_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_action = ACT_ADD;
   logic [SYM_BITS-1:0]   req_symbol = '0;
   logic                  rsp_valid;
   logic                  rsp_stall  = 1'b0;
   logic [COUNT_BITS-1:0] rsp_symbol_count;
   logic                  rsp_seen;
   logic [FREQ_BITS-1:0]  rsp_frequency;
   logic [COUNT_BITS-1:0] rsp_selected_total;
   logic [COUNT_BITS-1:0] rsp_all_total;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [WSEL_BITS-1:0]  csr_index  = '0;
   logic [WORD_BITS-1:0]  csr_data   = '0;

   hist_beat_type    queued_beats[$];
   hist_result_type  pending_results[$];
   hist_beat_type    next_beat;

   count_type            bin_tally[NUM_BINS];
   count_type            picked_tally;
   count_type            all_tally;
   logic [WORD_BITS-1:0] sel_mask[MASK_WORDS];
   logic [SYM_BITS-1:0]  hot_symbols[8];

   int idle_pct        = 30;
   int send_gap        = 0;
   int hold_left       = 0;
   int idle_cycles     = 0;
   int beats_queued    = 0;
   int beats_accepted  = 0;
   int results_checked = 0;
   int error_count     = 0;
   int add_beats       = 0;
   int query_beats     = 0;
   int clear_beats     = 0;
   int unused_beats    = 0;
   int freq_hits       = 0;
   int mask_settings   = 0;
   bit pressure_done   = 1'b0;

   byte_histogram_frequency dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_symbol         (req_symbol),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_symbol_count   (rsp_symbol_count),
      .rsp_seen           (rsp_seen),
      .rsp_frequency      (rsp_frequency),
      .rsp_selected_total (rsp_selected_total),
      .rsp_all_total      (rsp_all_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      clock = 1'b0;
      #(HALF_PERIOD);
      clock = 1'b1;
      #(HALF_PERIOD);
   end

   function automatic count_type bump(input count_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic int pick_gap(input int pct);
      if ($urandom_range(0, 99) >= pct) begin
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic hist_result_type histogram_predict(input action_type act,
                                                         input logic [SYM_BITS-1:0] sym);
      hist_result_type res;
      logic            picked;
      count_type       tally;
      logic [63:0]     scaled;
      picked = sel_mask[sym[SYM_BITS-1:BSEL_BITS]][sym[BSEL_BITS-1:0]];
      if (act == ACT_ADD) begin
         bin_tally[sym] = bump(bin_tally[sym]);
         all_tally = bump(all_tally);
         if (picked) begin
            picked_tally = bump(picked_tally);
         end
      end else if (act == ACT_CLEAR) begin
         foreach (bin_tally[i]) begin
            bin_tally[i] = '0;
         end
         picked_tally = '0;
         all_tally = '0;
      end
      tally = bin_tally[sym];
      res.frequency = '0;
      if (act == ACT_QUERY && picked && tally != 0 && picked_tally != 0) begin
         if (tally >= picked_tally) begin
            res.frequency = FREQ_ONE;
         end else begin
            scaled = (64'(tally) << FRAC_BITS) / 64'(picked_tally);
            res.frequency = freq_type'(scaled);
         end
      end
      res.symbol_count   = tally;
      res.seen           = (tally != 0);
      res.selected_total = picked_tally;
      res.all_total      = all_tally;
      return res;
   endfunction

   function automatic void compare_field(input string label, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_results.push_back(histogram_predict(req_action, req_symbol));
            case (req_action)
               ACT_ADD: begin
                  add_beats++;
               end
               ACT_QUERY: begin
                  query_beats++;
               end
               ACT_CLEAR: begin
                  clear_beats++;
               end
               default: begin
                  unused_beats++;
               end
            endcase
            beats_accepted++;
            send_gap = pick_gap(idle_pct);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (queued_beats.size() > 0) begin
               next_beat = queued_beats.pop_front();
               req_valid  <= 1'b1;
               req_action <= next_beat.action;
               req_symbol <= next_beat.symbol;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t ns: result beat with no expectation waiting", $time);
               error_count++;
            end else begin
               hist_result_type want;
               want = pending_results.pop_front();
               compare_field("symbol_count", want.symbol_count, rsp_symbol_count);
               compare_field("seen", 32'(want.seen), 32'(rsp_seen));
               compare_field("frequency", 32'(want.frequency), 32'(rsp_frequency));
               compare_field("selected_total", want.selected_total, rsp_selected_total);
               compare_field("all_total", want.all_total, rsp_all_total);
               if (want.frequency != 0) begin
                  freq_hits++;
               end
            end
            results_checked++;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else begin
            hold_left = pick_gap(idle_pct);
         end
         if (!pressure_done && results_checked >= PRESSURE_AT) begin
            hold_left = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end
         rsp_stall <= (hold_left > 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a beat.", idle_cycles);
         $display("[byte_histogram_frequency] ERROR");
         $finish;
      end
   end

   task automatic queue_beat(input action_type act, input logic [SYM_BITS-1:0] sym);
      hist_beat_type beat;
      beat.action = act;
      beat.symbol = sym;
      queued_beats.push_back(beat);
      beats_queued++;
   endtask

   task automatic drain();
      while (beats_accepted != beats_queued || pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask(input logic [WSEL_BITS-1:0] idx, input logic [WORD_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      sel_mask[idx] = data;
   endtask

   task automatic load_masks(input logic [WORD_BITS-1:0] w0, input logic [WORD_BITS-1:0] w1,
                             input logic [WORD_BITS-1:0] w2, input logic [WORD_BITS-1:0] w3);
      drain();
      write_mask(REG_MASK_W0, w0);
      write_mask(REG_MASK_W1, w1);
      write_mask(REG_MASK_W2, w2);
      write_mask(REG_MASK_W3, w3);
      mask_settings++;
   endtask

   task automatic queue_random(input int count);
      int                  roll;
      action_type          act;
      logic [SYM_BITS-1:0] sym;
      foreach (hot_symbols[i]) begin
         hot_symbols[i] = SYM_BITS'($urandom_range(0, NUM_BINS - 1));
      end
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 58) begin
            act = ACT_ADD;
         end else if (roll < 92) begin
            act = ACT_QUERY;
         end else if (roll < 95) begin
            act = ACT_CLEAR;
         end else begin
            act = ACT_UNUSED;
         end
         roll = $urandom_range(0, 9);
         if (roll < 5) begin
            sym = hot_symbols[3'($urandom_range(0, 7))];
         end else if (roll == 5) begin
            sym = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end else begin
            sym = SYM_BITS'($urandom_range(0, NUM_BINS - 1));
         end
         queue_beat(act, sym);
      end
   endtask

   function automatic logic [WORD_BITS-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   initial begin
      foreach (bin_tally[i]) begin
         bin_tally[i] = '0;
      end
      foreach (sel_mask[i]) begin
         sel_mask[i] = '0;
      end
      picked_tally = '0;
      all_tally = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // With the reset mask nothing is selected, so every frequency is zero.
      queue_beat(ACT_QUERY, 8'h00);
      queue_beat(ACT_ADD, 8'h00);
      queue_beat(ACT_ADD, 8'hFF);
      queue_beat(ACT_ADD, 8'hFF);
      queue_beat(ACT_QUERY, 8'hFF);
      queue_beat(ACT_UNUSED, 8'hFF);
      queue_beat(ACT_UNUSED, 8'h07);
      queue_beat(ACT_CLEAR, 8'h80);
      queue_beat(ACT_QUERY, 8'hFF);
      queue_beat(ACT_ADD, 8'h55);
      queue_beat(ACT_ADD, 8'hAA);
      load_masks('1, '0, 64'h5555_5555_5555_5555, '1);

      // Symbol 0xAA was counted while unselected, so its count can exceed the total.
      queue_beat(ACT_QUERY, 8'hAA);
      queue_beat(ACT_ADD, 8'h00);
      queue_beat(ACT_QUERY, 8'hAA);
      queue_beat(ACT_ADD, 8'hAA);
      queue_beat(ACT_ADD, 8'hAA);
      queue_beat(ACT_QUERY, 8'hAA);
      queue_beat(ACT_ADD, 8'h01);
      queue_beat(ACT_ADD, 8'h02);
      queue_beat(ACT_QUERY, 8'h00);
      queue_beat(ACT_QUERY, 8'hAA);
      queue_beat(ACT_QUERY, 8'h01);
      queue_beat(ACT_ADD, 8'h40);
      queue_beat(ACT_QUERY, 8'h40);
      queue_beat(ACT_QUERY, 8'hFF);
      queue_beat(ACT_CLEAR, 8'h00);
      queue_beat(ACT_QUERY, 8'hAA);

      idle_pct = 30;
      load_masks(rand_word(), rand_word(), rand_word(), rand_word());
      queue_random(PHASE_BEATS);

      idle_pct = 0;
      load_masks('1, '1, '1, '1);
      queue_random(PHASE_BEATS);

      idle_pct = 40;
      load_masks('0, '0, '0, '0);
      queue_random(PHASE_BEATS);

      idle_pct = 20;
      load_masks(rand_word() & rand_word() & rand_word(), rand_word() & rand_word(),
                 rand_word() | rand_word(), rand_word() & rand_word() & rand_word());
      queue_random(PHASE_BEATS);

      idle_pct = 10;
      load_masks(64'h1, rand_word(), rand_word(), 64'h8000_0000_0000_0000);
      queue_random(PHASE_BEATS);

      drain();
      if (pending_results.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
         error_count++;
      end
      $display("Sent %0d adds, %0d queries, %0d clears and %0d unused-code beats.",
               add_beats, query_beats, clear_beats, unused_beats);
      $display("Checked %0d results (%0d nonzero frequencies) over %0d mask settings.",
               results_checked, freq_hits, mask_settings);
      if (error_count == 0) begin
         $display("[byte_histogram_frequency] OK");
      end else begin
         $display("[byte_histogram_frequency] ERROR");
      end
      $finish;
   end

endmodule
